@@ rtl/core/mppd_pkg.sv @@
// ----------------------------------------------------------------------------
// mppd_pkg: shared types for the minimum point-to-plane distance block
// Multiplier operand selects and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mppd_pkg;

   // Packed request payload width (six Q16.16 coordinates, three Q2.14 normals)
   localparam int unsigned ReqDataWidth = 240;
   localparam int unsigned RspDataWidth = 32;

   // Operand pairs for the shared multiplier
   typedef enum logic [2:0] {
      MUL_DX_NX = 3'd0,
      MUL_DY_NY = 3'd1,
      MUL_DZ_NZ = 3'd2,
      MUL_NX_NX = 3'd3,
      MUL_NY_NY = 3'd4,
      MUL_NZ_NZ = 3'd5,
      MUL_LO_LO = 3'd6,
      MUL_HI_LO = 3'd7
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        load;        // capture the accepted request
      mul_sel_type mul_sel;
      logic        mul_hi_hi;   // overrides mul_sel with hi * hi
      logic        dot_load;
      logic        dot_add;
      logic        s_load;
      logic        s_add;
      logic        a_load;      // magnitude of the dot product
      logic        x_load;      // lo * lo term of A^2
      logic        x_add_mid;   // 2 * hi * lo term
      logic        x_add_high;  // hi * hi term
      logic        root_init;
      logic        root_step;
      logic        fold;        // fold distance into running minimum
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rsp_busy;           // result register still holds an untaken result
   } status_type;

endpackage

@@ rtl/core/mppd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mppd_ctrl: sequencer for the point-to-plane distance datapath
// Steps one item through the multiply schedule, the 32-step root recurrence
// and the fold into the running minimum.
// ----------------------------------------------------------------------------
module mppd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mppd_pkg::status_type status,
   output mppd_pkg::cmd_type   cmd
);
   import mppd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MATH = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_FOLD = 4'b1000
   } state_type;

   localparam logic [4:0] MathLast = 5'd9;
   localparam logic [4:0] RootLast = 5'd31;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and step count
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               state_in = ST_MATH;
            end
         end
         ST_MATH: begin
            step_in = step_ff + 5'd1;
            if (step_ff == MathLast) begin
               state_in = ST_ROOT;
               step_in  = '0;
            end
         end
         ST_ROOT: begin
            step_in = step_ff + 5'd1;
            if (step_ff == RootLast) begin
               state_in = ST_FOLD;
               step_in  = '0;
            end
         end
         ST_FOLD: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Command decode
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_DX_NX;
      cmd.load    = (state_ff == ST_IDLE) && req_tvalid;
      if (state_ff == ST_MATH) begin
         unique case (step_ff)
            5'd0: cmd.mul_sel = MUL_DX_NX;
            5'd1: begin
               cmd.mul_sel  = MUL_DY_NY;
               cmd.dot_load = 1'b1;
            end
            5'd2: begin
               cmd.mul_sel = MUL_DZ_NZ;
               cmd.dot_add = 1'b1;
            end
            5'd3: begin
               cmd.mul_sel = MUL_NX_NX;
               cmd.dot_add = 1'b1;
            end
            5'd4: begin
               cmd.mul_sel = MUL_NY_NY;
               cmd.s_load  = 1'b1;
               cmd.a_load  = 1'b1;
            end
            5'd5: begin
               cmd.mul_sel = MUL_NZ_NZ;
               cmd.s_add   = 1'b1;
            end
            5'd6: begin
               cmd.mul_sel = MUL_LO_LO;
               cmd.s_add   = 1'b1;
            end
            5'd7: begin
               cmd.mul_sel = MUL_HI_LO;
               cmd.x_load  = 1'b1;
            end
            5'd8: begin
               cmd.mul_hi_hi = 1'b1;
               cmd.x_add_mid = 1'b1;
            end
            5'd9: begin
               cmd.x_add_high = 1'b1;
               cmd.root_init  = 1'b1;
            end
            default: cmd.mul_sel = MUL_DX_NX;
         endcase
      end
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.fold      = (state_ff == ST_FOLD) && !status.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/core/mppd_datapath.sv @@
// ----------------------------------------------------------------------------
// mppd_datapath: arithmetic for the point-to-plane distance
// Shared 34x26 multiplier builds n.(q-p), |n|^2 and A^2; a restoring root
// recurrence finds the largest q with q*q*S <= A*A, one bit per cycle.
// ----------------------------------------------------------------------------
module mppd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mppd_pkg::cmd_type                     cmd,
   output mppd_pkg::status_type                  status,
   input  logic [mppd_pkg::ReqDataWidth-1:0]     req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mppd_pkg::RspDataWidth-1:0]     rsp_tdata
);
   import mppd_pkg::*;

   // Captured item
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic               last_ff;

   // Arithmetic registers
   logic signed [59:0] prod_ff;
   logic signed [49:0] dot_ff;
   logic [31:0]        s_ff;
   logic [48:0]        a_ff;
   logic [97:0]        x_ff;
   logic [99:0]        u_ff, v_ff;
   logic [31:0]        q_ff;

   // Result and running minimum
   logic [31:0]        min_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_valid_ff;

   logic signed [33:0] op_a;
   logic signed [25:0] op_b;
   logic [24:0]        a_lo;
   logic [23:0]        a_hi;
   logic [49:0]        dot_abs;
   logic [99:0]        inc;
   logic               take;
   logic [99:0]        u_sum;
   logic [31:0]        plane_dist;
   logic [31:0]        new_min;

   assign a_lo = a_ff[24:0];
   assign a_hi = a_ff[48:25];

   // Multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (cmd.mul_hi_hi) begin
         op_a = {10'd0, a_hi};
         op_b = {2'd0, a_hi};
      end else begin
         case (cmd.mul_sel)
            MUL_DX_NX: begin
               op_a = {dx_ff[32], dx_ff};
               op_b = {{10{nx_ff[15]}}, nx_ff};
            end
            MUL_DY_NY: begin
               op_a = {dy_ff[32], dy_ff};
               op_b = {{10{ny_ff[15]}}, ny_ff};
            end
            MUL_DZ_NZ: begin
               op_a = {dz_ff[32], dz_ff};
               op_b = {{10{nz_ff[15]}}, nz_ff};
            end
            MUL_NX_NX: begin
               op_a = {{18{nx_ff[15]}}, nx_ff};
               op_b = {{10{nx_ff[15]}}, nx_ff};
            end
            MUL_NY_NY: begin
               op_a = {{18{ny_ff[15]}}, ny_ff};
               op_b = {{10{ny_ff[15]}}, ny_ff};
            end
            MUL_NZ_NZ: begin
               op_a = {{18{nz_ff[15]}}, nz_ff};
               op_b = {{10{nz_ff[15]}}, nz_ff};
            end
            MUL_LO_LO: begin
               op_a = {9'd0, a_lo};
               op_b = {1'b0, a_lo};
            end
            MUL_HI_LO: begin
               op_a = {10'd0, a_hi};
               op_b = {1'b0, a_lo};
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end
   end

   assign dot_abs = dot_ff[49] ? 50'(-dot_ff) : 50'(dot_ff);

   // Root recurrence: compare U + V against the remainder; a taken bit
   // moves U to U + 2V before the halving
   assign inc   = u_ff + v_ff;
   assign take  = (inc <= {2'd0, x_ff});
   assign u_sum = take ? (inc + v_ff) : u_ff;

   // Distance and minimum update
   assign plane_dist = (s_ff == '0) ? '0 : q_ff;
   assign new_min    = (plane_dist < min_ff) ? plane_dist : min_ff;

   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   // Item capture: coordinate differences are exact 33 bit values
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= 33'($signed(req_tdata[31:0]))  - 33'($signed(req_tdata[127:96]));
         dy_ff   <= 33'($signed(req_tdata[63:32])) - 33'($signed(req_tdata[159:128]));
         dz_ff   <= 33'($signed(req_tdata[95:64])) - 33'($signed(req_tdata[191:160]));
         nx_ff   <= req_tdata[207:192];
         ny_ff   <= req_tdata[223:208];
         nz_ff   <= req_tdata[239:224];
         last_ff <= req_tlast;
      end
   end

   // Multiply and accumulate
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (cmd.dot_load) begin
         dot_ff <= prod_ff[49:0];
      end else if (cmd.dot_add) begin
         dot_ff <= dot_ff + prod_ff[49:0];
      end
      if (cmd.s_load) begin
         s_ff <= prod_ff[31:0];
      end else if (cmd.s_add) begin
         s_ff <= s_ff + prod_ff[31:0];
      end
      if (cmd.a_load) begin
         a_ff <= dot_abs[48:0];
      end
   end

   // A^2 assembly and root recurrence
   always_ff @(posedge clock) begin
      if (cmd.x_load) begin
         x_ff <= {48'd0, prod_ff[49:0]};
      end else if (cmd.x_add_mid) begin
         x_ff <= x_ff + {23'd0, prod_ff[48:0], 26'd0};
      end else if (cmd.x_add_high) begin
         x_ff <= x_ff + {prod_ff[47:0], 50'd0};
      end else if (cmd.root_step && take) begin
         x_ff <= x_ff - inc[97:0];
      end
      if (cmd.root_init) begin
         u_ff <= '0;
         v_ff <= {6'd0, s_ff, 62'd0};
         q_ff <= '0;
      end else if (cmd.root_step) begin
         u_ff <= {1'b0, u_sum[99:1]};
         v_ff <= {2'd0, v_ff[99:2]};
         q_ff <= {q_ff[30:0], take};
      end
   end

   // Running minimum and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.fold) begin
            if (last_ff) begin
               min_ff       <= '1;
               rsp_valid_ff <= 1'b1;
            end else begin
               min_ff <= new_min;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fold && last_ff) begin
         rsp_data_ff <= new_min;
      end
   end

endmodule

@@ rtl/core/min_point_to_plane_distance.sv @@
// ----------------------------------------------------------------------------
// min_point_to_plane_distance: running minimum of point-to-plane distances
// Top level joining the sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Each request carries a query point, a neighbor point and its normal; the
// block computes floor(|n.(q-p)| / |n|) in unsigned Q16.16 (0 for a zero
// normal, saturating at all ones) and keeps the minimum over the run. On the
// transfer marked tlast it emits the minimum and restarts. Per item, the
// shared multiplier forms the dot product, |n|^2 and the square of the dot,
// then the one-bit-per-cycle root recurrence finds the quotient and a fold
// updates the minimum. A new request is taken the cycle after the fold, so
// only one item is in flight at a time; a result still waiting in the
// output register holds the fold of the next item, whether last or not,
// until it is taken.
module min_point_to_plane_distance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // query_x, query_y, query_z, neighbor_x, neighbor_y, neighbor_z,
   // nrm_x, nrm_y, nrm_z (lowest bit first)
   input  logic [mppd_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                               req_tlast,   // last_neighbor
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mppd_pkg::RspDataWidth-1:0]  rsp_tdata    // min_distance
);
   import mppd_pkg::*;

   cmd_type    cmd;
   status_type status;

   mppd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mppd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // One item in flight: no request right after a transfer
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in flight");

   // A result appears only out of a fold
   a_rsp_from_fold : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.fold))
      else $error("result raised without a fold");

endmodule

@@ bench/min_distance_checker.sv @@
// ----------------------------------------------------------------------------
// min_distance_checker: watches the neighbor and distance streams
// Recomputes each neighbor's plane distance, folds it into its own running
// minimum, queues the minimum on a last transfer and compares every result.
// ----------------------------------------------------------------------------
module min_distance_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [mppd_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mppd_pkg::RspDataWidth-1:0] rsp_tdata,
   output int                                fail_count,
   output int                                pending_count
);

   logic [31:0] group_minimum;
   logic [31:0] expected_minima[$];

   assign pending_count = expected_minima.size();

   // floor(|n.(q-p)| / |n|), saturating at all ones, zero for a zero normal
   function automatic logic [31:0] plane_distance(logic [239:0] d);
      logic signed [63:0]  dx, dy, dz, nx, ny, nz, dot;
      logic        [127:0] a2, lhs;
      logic        [63:0]  mag, s;
      logic        [31:0]  q, c;
      dx = 64'(signed'(d[31:0]))   - 64'(signed'(d[127:96]));
      dy = 64'(signed'(d[63:32]))  - 64'(signed'(d[159:128]));
      dz = 64'(signed'(d[95:64]))  - 64'(signed'(d[191:160]));
      nx = 64'(signed'(d[207:192]));
      ny = 64'(signed'(d[223:208]));
      nz = 64'(signed'(d[239:224]));
      dot = dx * nx + dy * ny + dz * nz;
      mag = dot < 0 ? -dot : dot;
      s = nx * nx + ny * ny + nz * nz;
      if (s == 0) return 32'd0;
      a2 = 128'(mag) * 128'(mag);
      q = 32'd0;
      for (int b = 31; b >= 0; b--) begin
         c = q | (32'd1 << b);
         lhs = 128'(c) * 128'(c) * 128'(s);
         if (lhs <= a2) q = c;
      end
      return q;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Predict on each neighbor transfer, compare on each result transfer
   always @(posedge clock) begin
      logic [31:0] item_dist;
      if (reset) begin
         group_minimum <= '1;
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            item_dist = plane_distance(req_tdata);
            if (req_tlast) begin
               expected_minima = {expected_minima,
                  (item_dist < group_minimum ? item_dist : group_minimum)};
               group_minimum <= '1;
            end else if (item_dist < group_minimum) begin
               group_minimum <= item_dist;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_minima.size() == 0)
               report("unexpected min_distance", rsp_tdata, 32'h0);
            else if (rsp_tdata !== expected_minima[0])
               report("min_distance", rsp_tdata, expected_minima.pop_front());
            else
               void'(expected_minima.pop_front());
         end
      end
   end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for min_point_to_plane_distance
// Directed extremes, then random neighbor groups with random gaps on both
// sides, a long result stall and a drain pause; checking is in the checker.
// ----------------------------------------------------------------------------
module testbench;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [mppd_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic                              req_tlast = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [mppd_pkg::RspDataWidth-1:0] rsp_tdata;
   int                                fail_count, pending_count;
   bit                                stall_window = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   min_point_to_plane_distance DUT (.*);

   min_distance_checker checker_i (.*);

   // Coordinate: extremes, small values, or anything
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, 31'h0};
         1: return {1'b0, {31{1'b1}}};
         2, 3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_normal();
      case ($urandom_range(0, 6))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   // One neighbor transfer: gap with valid low, then hold until accepted
   task automatic send(logic [239:0] d, logic last);
      int gap;
      gap = $urandom_range(0, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [239:0] random_item();
      return {pick_normal(), pick_normal(), pick_normal(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord()};
   endfunction

   // Result side ready: a random gap before each result, one long stall
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (stall_window) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            stall_window = 1'b0;
         end else begin
            gap = $urandom_range(0, 13);
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            do @(posedge clock); while (!rsp_tvalid);
         end
      end
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [239:0] d;
      int groups;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero normal, saturation, single-item and three-item groups
      send({48'h0, 96'h0, 96'h0}, 1'b1);
      send({16'h0, 16'h0, 16'h4000, 96'h0, 32'h0, 32'h0, 32'h00010000}, 1'b1);
      send({16'h0, 16'h0, 16'h0001, 64'h0, 32'h80000000, 64'h0, 32'h7fffffff}, 1'b1);
      send({16'h8000, 16'h8000, 16'h8000, {3{32'h80000000}}, {3{32'h7fffffff}}}, 1'b1);
      send({16'h7fff, 16'h8000, 16'h7fff, {3{32'h7fffffff}}, {3{32'h80000000}}}, 1'b0);
      send({16'h0, 16'h0, 16'h0, {3{32'h12345678}}, {3{32'h87654321}}}, 1'b0);
      send({16'hffff, 16'h0001, 16'h4000, {3{32'hffffffff}}, {3{32'h0}}}, 1'b1);
      send({16'h0001, 16'h0, 16'h0, 96'h0, 32'h0, 32'h0, 32'h7fffffff}, 1'b1);
      for (int i = 0; i < 8; i++) send(random_item(), i[0]);

      // Random groups of 1 to 8 neighbors; mid-run long stall and drain pause
      groups = 0;
      for (int n = 0; n < 1400; ) begin
         int len;
         len = $urandom_range(1, 8);
         if (groups == 60) stall_window = 1'b1;
         for (int k = 0; k < len; k++) send(random_item(), k == len - 1);
         n += len;
         groups++;
         if (groups == 120) begin
            req_tvalid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
